// ===== hw/rtl/rgbcm_pkg.sv =====
// rgbcm_pkg: shared types and constants of the rgb channel mixer
// payload structs, register index codes, fixed-point format constants
// no dependencies
`default_nettype none

package rgbcm_pkg;

    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 14;
    localparam int ROW_W     = 3 * GAIN_W;
    localparam int ABS_SUM_W = 17;
    localparam int OUT_W     = 20;
    localparam int OUT_FRAC  = 16;
    localparam int QUO_BITS  = OUT_W + 1;
    localparam int PLAIN_W   = 19;
    localparam int FRONT_STAGES = 3;

    localparam logic [QUO_BITS-1:0] OUT_MAX_MAG = QUO_BITS'(524287);
    localparam logic [QUO_BITS-1:0] OUT_MIN_MAG = QUO_BITS'(524288);

    localparam logic [ROW_W-1:0] RED_GAINS_RST   = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] GREEN_GAINS_RST = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] BLUE_GAINS_RST  = 48'h4000_0000_0000;

    typedef enum logic [1:0] {
        CFG_RED_GAINS,
        CFG_GREEN_GAINS,
        CFG_BLUE_GAINS,
        CFG_PRESERVE
    } rgbcm_cfg_idx_t;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [15:0] alpha_in;
        logic        last_in;
    } rgbcm_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] red_out;
        logic signed [OUT_W-1:0] green_out;
        logic signed [OUT_W-1:0] blue_out;
        logic [15:0]             alpha_out;
        logic                    last_out;
    } rgbcm_out_t;

    // per-row control carried alongside the divider
    typedef struct packed {
        logic               neg;
        logic               use_div;
        logic [PLAIN_W-1:0] plain_q;
    } rgbcm_side_t;

    // alpha and last mark riding the pipeline
    typedef struct packed {
        logic [15:0] alpha;
        logic        last;
    } rgbcm_pass_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgbcm_dot.sv =====
// rgbcm_dot: three-stage front end of one row: gain products, dot sum, magnitude
// uses rgbcm_pkg
`default_nettype none

module rgbcm_dot
    import rgbcm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [ROW_W-1:0]              gains,
    input  wire logic                          preserve,
    input  wire logic [SAMPLE_BITS-1:0]        red,
    input  wire logic [SAMPLE_BITS-1:0]        green,
    input  wire logic [SAMPLE_BITS-1:0]        blue,
    output logic [SAMPLE_BITS+OUT_FRAC+16:0]   num,
    output logic [SAMPLE_BITS+ABS_SUM_W-1:0]   den,
    output rgbcm_side_t                        side
);

    localparam int PW    = SAMPLE_BITS + GAIN_W + 1;
    localparam int DW    = SAMPLE_BITS + 18;
    localparam int MW    = DW - 1;
    localparam int SHIFT = GAIN_FRAC + SAMPLE_BITS - OUT_FRAC;

    logic signed [GAIN_W-1:0] g0, g1, g2;
    logic signed [GAIN_W+1:0] sum;
    logic signed [PW-1:0]     p0_next, p1_next, p2_next;
    logic [ABS_SUM_W-1:0]     abs_next;
    logic                     use_next;

    logic signed [PW-1:0]     p0_reg, p1_reg, p2_reg;
    logic [ABS_SUM_W-1:0]     abs_a_reg, abs_b_reg;
    logic                     use_a_reg, use_b_reg;
    logic signed [DW-1:0]     dot_reg;
    logic signed [DW-1:0]     dot_next;
    logic [MW-1:0]            mag;
    logic [DW-1:0]            neg_dot;

    always_comb
    begin
        g0 = $signed(gains[GAIN_W-1:0]);
        g1 = $signed(gains[2*GAIN_W-1:GAIN_W]);
        g2 = $signed(gains[3*GAIN_W-1:2*GAIN_W]);
        sum = (GAIN_W+2)'(g0) + (GAIN_W+2)'(g1) + (GAIN_W+2)'(g2);
        abs_next = sum[GAIN_W+1] ? ABS_SUM_W'(-sum) : ABS_SUM_W'(sum);
        use_next = preserve && (sum != '0);
        p0_next = PW'(g0 * $signed({1'b0, red}));
        p1_next = PW'(g1 * $signed({1'b0, green}));
        p2_next = PW'(g2 * $signed({1'b0, blue}));
    end

    always_comb
    begin
        dot_next = DW'(p0_reg) + DW'(p1_reg) + DW'(p2_reg);
        neg_dot  = -dot_reg;
        mag      = dot_reg[DW-1] ? neg_dot[MW-1:0] : dot_reg[MW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            abs_a_reg <= abs_next;
            use_a_reg <= use_next;
            // dot sum
            dot_reg   <= dot_next;
            abs_b_reg <= abs_a_reg;
            use_b_reg <= use_a_reg;
            // magnitude and divider operands
            num          <= {mag, {OUT_FRAC{1'b0}}};
            den          <= {abs_b_reg, {SAMPLE_BITS{1'b0}}};
            side.neg     <= dot_reg[DW-1];
            side.use_div <= use_b_reg;
            side.plain_q <= mag[MW-1:SHIFT];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rgbcm_div.sv =====
// rgbcm_div: pipelined restoring divider, one quotient bit per stage
// uses rgbcm_pkg; an overflow stage flags quotients beyond QUO_BITS bits
`default_nettype none

module rgbcm_div
    import rgbcm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic [SAMPLE_BITS+OUT_FRAC+16:0]     num,
    input  wire logic [SAMPLE_BITS+ABS_SUM_W-1:0]     den,
    input  wire rgbcm_side_t                          side_in,
    output logic [QUO_BITS-1:0]                       quo,
    output logic                                      ovf,
    output rgbcm_side_t                               side_out
);

    localparam int NW = SAMPLE_BITS + OUT_FRAC + 17;
    localparam int DNW = SAMPLE_BITS + ABS_SUM_W;
    localparam int RW = DNW + 1;

    logic [RW-2:0]       rem_reg  [0:QUO_BITS];
    logic [QUO_BITS-1:0] q_reg    [0:QUO_BITS];
    logic [QUO_BITS-1:0] low_reg  [0:QUO_BITS];
    logic [DNW-1:0]      den_reg  [0:QUO_BITS];
    logic                ovf_reg  [0:QUO_BITS];
    rgbcm_side_t         side_reg [0:QUO_BITS];

    logic [DNW-1:0] top_part;

    assign top_part = DNW'(num[NW-1:QUO_BITS]);

    // overflow check and initial partial remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= top_part[RW-2:0];
            q_reg[0]    <= '0;
            low_reg[0]  <= num[QUO_BITS-1:0];
            den_reg[0]  <= den;
            ovf_reg[0]  <= (top_part >= den);
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_step
        localparam int K = QUO_BITS - 1 - j;

        logic [RW-1:0]       trial;
        logic [RW-1:0]       diff;
        logic                ge;
        logic [RW-2:0]       rem_next;
        logic [QUO_BITS-1:0] q_next;

        always_comb
        begin
            trial    = {rem_reg[j], low_reg[j][K]};
            diff     = trial - {1'b0, den_reg[j]};
            ge       = (trial >= {1'b0, den_reg[j]});
            rem_next = ge ? diff[RW-2:0] : trial[RW-2:0];
            q_next    = q_reg[j];
            q_next[K] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= rem_next;
                q_reg[j+1]    <= q_next;
                low_reg[j+1]  <= low_reg[j];
                den_reg[j+1]  <= den_reg[j];
                ovf_reg[j+1]  <= ovf_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign quo      = q_reg[QUO_BITS];
    assign ovf      = ovf_reg[QUO_BITS];
    assign side_out = side_reg[QUO_BITS];

endmodule

`default_nettype wire

// ===== hw/rtl/rgbcm_sat.sv =====
// rgbcm_sat: picks divided or rescaled magnitude, applies sign and saturation
// uses rgbcm_pkg; output is registered
`default_nettype none

module rgbcm_sat
    import rgbcm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [QUO_BITS-1:0] quo,
    input  wire logic                ovf,
    input  wire rgbcm_side_t         side,
    output logic signed [OUT_W-1:0]  res
);

    logic [QUO_BITS-1:0]     mag;
    logic                    big;
    logic [QUO_BITS-1:0]     neg_mag;
    logic signed [OUT_W-1:0] res_next;

    always_comb
    begin
        mag = side.use_div ? quo : QUO_BITS'(side.plain_q);
        big = side.use_div && ovf;
        neg_mag = -mag;
        if (side.neg)
        begin
            res_next = (big || mag > OUT_MIN_MAG) ? $signed(OUT_MIN_MAG[OUT_W-1:0])
                                                   : $signed(neg_mag[OUT_W-1:0]);
        end
        else
        begin
            res_next = (big || mag > OUT_MAX_MAG) ? $signed(OUT_MAX_MAG[OUT_W-1:0])
                                                   : $signed(mag[OUT_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_channel_mixer_core.sv =====
// rgb_channel_mixer_core: top level of the 3x3 rgb channel mixer
// uses rgbcm_pkg, rgbcm_dot, rgbcm_div, rgbcm_sat
//
// usage
//   src channel: one rgba pixel item per accepted cycle (src_valid high,
//   src_stall low at a rising edge). dst channel: one mixed item per pixel,
//   taken when dst_valid is high and dst_stall low.
//   cfg port: cfg_we writes cfg_data into register cfg_index at the edge;
//   write only while no item is in flight.
// pipeline and throughput
//   an accepted item passes three front stages (products, dot sum,
//   magnitude), one overflow stage, 21 divider stages (one quotient
//   bit each) and one saturation/output register. unless stalled, one
//   item per cycle; divider fully pipelined, one copy per output row.
// stalls
//   the whole pipeline advances on one enable; it freezes only while a
//   finished item sits in the output register and dst_stall is high, and
//   src_stall is then raised. nothing is dropped or repeated.
// reset
//   rst_n clears all valid bits and loads identity gains with
//   preserve-luminosity off; datapath registers are not reset.
`default_nettype none

module rgb_channel_mixer_core
    import rgbcm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             src_valid,
    output logic                  src_stall,
    input  wire rgbcm_in_t        src_data,
    output logic                  dst_valid,
    input  wire logic             dst_stall,
    output rgbcm_out_t            dst_data,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [ROW_W-1:0] cfg_data
);

    // total register stages from src to dst
    localparam int LAT = FRONT_STAGES + 1 + QUO_BITS + 1;
    localparam int EXT = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int NW  = SAMPLE_BITS + OUT_FRAC + 17;
    localparam int DNW = SAMPLE_BITS + ABS_SUM_W;

    // configuration registers
    logic [ROW_W-1:0] red_gains_reg, green_gains_reg, blue_gains_reg;
    logic             preserve_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_gains_reg   <= RED_GAINS_RST;
            green_gains_reg <= GREEN_GAINS_RST;
            blue_gains_reg  <= BLUE_GAINS_RST;
            preserve_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (rgbcm_cfg_idx_t'(cfg_index))
                CFG_RED_GAINS:   red_gains_reg   <= cfg_data;
                CFG_GREEN_GAINS: green_gains_reg <= cfg_data;
                CFG_BLUE_GAINS:  blue_gains_reg  <= cfg_data;
                CFG_PRESERVE:    preserve_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // global advance: hold only when a finished item is blocked
    logic en;
    logic [LAT-1:0] vld_reg;

    assign en        = !(vld_reg[LAT-1] && dst_stall);
    assign src_stall = !en;
    assign dst_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], src_valid};
        end
    end

    // alpha and last mark ride alongside
    rgbcm_pass_t pass_reg [0:LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pass_reg[0].alpha <= src_data.alpha_in;
            pass_reg[0].last  <= src_data.last_in;
            for (int i = 1; i < LAT; i++)
            begin
                pass_reg[i] <= pass_reg[i-1];
            end
        end
    end

    // samples trimmed or widened to SAMPLE_BITS
    logic [EXT-1:0]         red_wide, green_wide, blue_wide;
    logic [SAMPLE_BITS-1:0] red_s, green_s, blue_s;

    always_comb
    begin
        red_wide   = EXT'(src_data.red_in);
        green_wide = EXT'(src_data.green_in);
        blue_wide  = EXT'(src_data.blue_in);
        red_s      = red_wide[SAMPLE_BITS-1:0];
        green_s    = green_wide[SAMPLE_BITS-1:0];
        blue_s     = blue_wide[SAMPLE_BITS-1:0];
    end

    logic [ROW_W-1:0]          row_gains [0:2];
    logic [NW-1:0]             num       [0:2];
    logic [DNW-1:0]            den       [0:2];
    rgbcm_side_t               side_f    [0:2];
    rgbcm_side_t               side_d    [0:2];
    logic [QUO_BITS-1:0]       quo       [0:2];
    logic                      ovf       [0:2];
    logic signed [OUT_W-1:0]   res       [0:2];

    assign row_gains[0] = red_gains_reg;
    assign row_gains[1] = green_gains_reg;
    assign row_gains[2] = blue_gains_reg;

    // one dot/divide/saturate lane per output channel
    for (genvar c = 0; c < 3; c++)
    begin : g_row
        rgbcm_dot #(.SAMPLE_BITS(SAMPLE_BITS)) u_dot (
            .clk      (clk),
            .en       (en),
            .gains    (row_gains[c]),
            .preserve (preserve_reg),
            .red      (red_s),
            .green    (green_s),
            .blue     (blue_s),
            .num      (num[c]),
            .den      (den[c]),
            .side     (side_f[c])
        );

        rgbcm_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
            .clk      (clk),
            .en       (en),
            .num      (num[c]),
            .den      (den[c]),
            .side_in  (side_f[c]),
            .quo      (quo[c]),
            .ovf      (ovf[c]),
            .side_out (side_d[c])
        );

        rgbcm_sat u_sat (
            .clk  (clk),
            .en   (en),
            .quo  (quo[c]),
            .ovf  (ovf[c]),
            .side (side_d[c]),
            .res  (res[c])
        );
    end

    always_comb
    begin
        dst_data.red_out   = res[0];
        dst_data.green_out = res[1];
        dst_data.blue_out  = res[2];
        dst_data.alpha_out = pass_reg[LAT-1].alpha;
        dst_data.last_out  = pass_reg[LAT-1].last;
    end

endmodule

`default_nettype wire
